### design/esu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the escape sequence unescaper.
package esu_pkg;

    localparam int unsigned CHAR_W         = 21;
    localparam int unsigned ACC_W          = 16;
    localparam int unsigned CNT_W          = 3;
    localparam int unsigned MAX_HEX_DIGITS = 4;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = CHAR_W'(8'h5C);
    localparam logic [CHAR_W-1:0] CH_U         = CHAR_W'(8'h75);
    localparam logic [CHAR_W-1:0] CH_T         = CHAR_W'(8'h74);
    localparam logic [CHAR_W-1:0] CH_R         = CHAR_W'(8'h72);
    localparam logic [CHAR_W-1:0] CH_N         = CHAR_W'(8'h6E);
    localparam logic [CHAR_W-1:0] CH_A         = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] CH_TAB       = CHAR_W'(8'h09);
    localparam logic [CHAR_W-1:0] CH_CR        = CHAR_W'(8'h0D);
    localparam logic [CHAR_W-1:0] CH_LF        = CHAR_W'(8'h0A);
    localparam logic [CHAR_W-1:0] CH_BEL       = CHAR_W'(8'h07);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              run_end;
        logic              string_end;
    } t_result;

    // Results produced by one input beat: count, then up to two entries in order.
    typedef struct packed {
        logic [1:0] n;
        t_result    first;
        t_result    second;
    } t_decode;

    // Returns {is_hex, value}; only ASCII digits and letters A-F / a-f count.
    function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [6:0] a;
        a = c[6:0];
        hex_nibble = '0;
        if (c[CHAR_W-1:7] == '0) begin
            if (a >= 7'h30 && a <= 7'h39) begin
                hex_nibble = {1'b1, 4'(a - 7'h30)};
            end else if (a >= 7'h41 && a <= 7'h46) begin
                hex_nibble = {1'b1, 4'(a - 7'h37)};
            end else if (a >= 7'h61 && a <= 7'h66) begin
                hex_nibble = {1'b1, 4'(a - 7'h57)};
            end
        end
    endfunction

    function automatic logic [CHAR_W-1:0] map_escape(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] m;
        m = c;
        if (c == CH_T) begin
            m = CH_TAB;
        end else if (c == CH_R) begin
            m = CH_CR;
        end else if (c == CH_N) begin
            m = CH_LF;
        end else if (c == CH_A) begin
            m = CH_BEL;
        end
        return m;
    endfunction

endpackage

### design/esu_in_if.sv
`timescale 1ns / 1ps
// Input character stream channel.
interface esu_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] in_char;
    logic        in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

### design/esu_out_if.sv
`timescale 1ns / 1ps
// Output character stream channel.
interface esu_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] out_char;
    logic        run_end;
    logic        string_end;

    modport source (output valid, output out_char, output run_end, output string_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input string_end,
                    output ready);
endinterface

### design/escape_sequence_unescaper.sv
`timescale 1ns / 1ps
// Results are registered in the three-entry output buffer before they reach the output.
// Throughput: one input beat per cycle while the output is ready; a beat that yields
// two results holds off the input while the output buffer drains.
// Reset (synchronous, active low) returns the parser to normal mode, clears the hex
// digit state and empties the output buffer; the input is ready the cycle after.
module escape_sequence_unescaper
    import esu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    esu_in_if.sink    i_in_stream,
    esu_out_if.source o_out_stream
);

    logic    w_space;
    logic    w_beat;
    t_decode w_dec;

    assign i_in_stream.ready = w_space;
    assign w_beat            = i_in_stream.valid && w_space;

    esu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .i_char  (i_in_stream.in_char),
        .i_last  (i_in_stream.in_last),
        .o_dec   (w_dec)
    );

    esu_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_beat),
        .i_dec   (w_dec),
        .o_space (w_space),
        .o_out   (o_out_stream)
    );

endmodule

### design/esu_decode.sv
`timescale 1ns / 1ps
// Escape parser: parse state registers and the per-beat result logic.
module esu_decode
    import esu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output t_decode           o_dec
);

    t_mode             r_mode;
    t_mode             n_mode;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;

    logic [4:0]        w_hex;
    logic              w_take;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [ACC_W-1:0]  w_acc_next;
    logic              w_full;
    logic              w_as_normal;
    logic              a_valid;
    logic [CHAR_W-1:0] a_val;
    logic              b_valid;

    assign w_hex      = hex_nibble(i_char);
    assign w_take     = w_hex[4] && (r_cnt < CNT_W'(MAX_HEX_DIGITS));
    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_acc_next = {r_acc[ACC_W-5:0], w_hex[3:0]};
    assign w_full     = (w_cnt_inc >= CNT_W'(MAX_HEX_DIGITS));

    // A non-hex terminator of a u escape is then treated as an ordinary character.
    assign w_as_normal = (r_mode == MODE_HEX) ? !w_take : (r_mode != MODE_ESCAPE);

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        unique case (r_mode)
            MODE_HEX: begin
                if (w_take) begin
                    n_acc = w_acc_next;
                    n_cnt = w_cnt_inc;
                    if (w_full) begin
                        n_mode = MODE_NORMAL;
                    end
                end else begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_ESCAPE: begin
                if (i_char == CH_U) begin
                    n_mode = MODE_HEX;
                    n_cnt  = '0;
                    n_acc  = '0;
                end else begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
            end
        endcase
        if (w_as_normal) begin
            n_mode = (i_char == CH_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
        end
        if (i_last) begin
            n_mode = MODE_NORMAL;
            n_cnt  = '0;
            n_acc  = '0;
        end
    end

    always_comb begin
        a_valid = 1'b0;
        a_val   = '0;
        unique case (r_mode)
            MODE_HEX: begin
                if (w_take) begin
                    a_valid = w_full || i_last;
                    a_val   = CHAR_W'(w_acc_next);
                end else begin
                    a_valid = (r_cnt != '0);
                    a_val   = CHAR_W'(r_acc);
                end
            end
            MODE_ESCAPE: begin
                a_valid = (i_char != CH_U);
                a_val   = map_escape(i_char);
            end
            default: begin
                a_valid = 1'b0;
            end
        endcase
        b_valid = w_as_normal && (i_char != CH_BACKSLASH);

        o_dec.n                   = 2'(a_valid) + 2'(b_valid);
        o_dec.first.out_char      = a_valid ? a_val : i_char;
        o_dec.first.run_end       = !(a_valid && b_valid);
        o_dec.first.string_end    = !(a_valid && b_valid) && i_last;
        o_dec.second.out_char     = i_char;
        o_dec.second.run_end      = 1'b1;
        o_dec.second.string_end   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= '0;
            r_acc  <= '0;
        end else if (i_beat) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_HEX_DIGITS))
        else $error("hex digit count beyond limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_mode == MODE_NORMAL && r_cnt == '0 && r_acc == '0))
        else $error("parse state not cleared after end of string");

endmodule

### design/esu_out_queue.sv
`timescale 1ns / 1ps
// Three-entry result buffer that drives the output channel.
module esu_out_queue
    import esu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_decode   i_dec,
    output logic      o_space,
    esu_out_if.source o_out
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_slot [3];
    t_result    n_slot [3];
    logic       w_pop;
    logic [1:0] w_push_n;
    logic [1:0] w_base;

    assign w_pop    = (r_count != 2'd0) && o_out.ready;
    assign w_push_n = i_push ? i_dec.n : 2'd0;
    assign w_base   = r_count - 2'(w_pop);
    assign n_count  = w_base + w_push_n;

    // Room for a full two-result beat is kept, so the space flag is purely registered.
    assign o_space  = (r_count <= 2'd1);

    always_comb begin
        n_slot = r_slot;
        if (w_pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
        end
        for (int i = 0; i < 3; i++) begin
            if (w_push_n != 2'd0 && 2'(i) == w_base) begin
                n_slot[i] = i_dec.first;
            end
            if (w_push_n == 2'd2 && 2'(i) == w_base + 2'd1) begin
                n_slot[i] = i_dec.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_out.valid      = (r_count != 2'd0);
    assign o_out.out_char   = r_slot[0].out_char;
    assign o_out.run_end    = r_slot[0].run_end;
    assign o_out.string_end = r_slot[0].string_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= 2'd2) |-> (w_push_n == 2'd0))
        else $error("result pushed into a full buffer");

    a_string_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> o_out.run_end)
        else $error("string end flagged on a result that is not the last of its beat");

endmodule

### tb/sv/unescape_checker.sv
`timescale 1ns / 1ps
// Watches both character channels, predicts the unescaped stream and compares every beat.
module unescape_checker
    import esu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    esu_in_if    i_in_mon,
    esu_out_if   i_out_mon,
    output int   o_pending,
    output int   o_fail_count
);

    t_mode             parse_state;
    logic [CNT_W-1:0]  digits_held;
    logic [ACC_W-1:0]  hex_value;
    t_result           awaited_chars[$];
    int                mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    // Works out the characters that one input beat releases and queues them in order.
    task automatic unescape_step(input logic [CHAR_W-1:0] ch, input logic last);
        logic [CHAR_W-1:0] vals[2];
        int                n;
        logic              plain;
        logic              is_hex;
        logic [3:0]        nib;
        n      = 0;
        plain  = 1'b0;
        is_hex = 1'b1;
        nib    = '0;
        if (ch >= "0" && ch <= "9") begin
            nib = 4'(ch - "0");
        end else if (ch >= "A" && ch <= "F") begin
            nib = 4'(ch - "A" + 10);
        end else if (ch >= "a" && ch <= "f") begin
            nib = 4'(ch - "a" + 10);
        end else begin
            is_hex = 1'b0;
        end

        case (parse_state)
            MODE_HEX: begin
                if (is_hex && digits_held < MAX_HEX_DIGITS) begin
                    hex_value   = {hex_value[ACC_W-5:0], nib};
                    digits_held = digits_held + 1'b1;
                    if (digits_held >= MAX_HEX_DIGITS) begin
                        vals[n]     = CHAR_W'(hex_value);
                        n++;
                        parse_state = MODE_NORMAL;
                    end else if (last) begin
                        vals[n] = CHAR_W'(hex_value);
                        n++;
                    end
                end else begin
                    // A non-hex character closes the escape and is then taken as ordinary text.
                    if (digits_held != 0) begin
                        vals[n] = CHAR_W'(hex_value);
                        n++;
                    end
                    parse_state = MODE_NORMAL;
                    plain       = 1'b1;
                end
            end
            MODE_ESCAPE: begin
                if (ch == CH_U) begin
                    parse_state = MODE_HEX;
                    digits_held = '0;
                    hex_value   = '0;
                end else begin
                    case (ch)
                        CH_T:    vals[n] = CH_TAB;
                        CH_R:    vals[n] = CH_CR;
                        CH_N:    vals[n] = CH_LF;
                        CH_A:    vals[n] = CH_BEL;
                        default: vals[n] = ch;
                    endcase
                    n++;
                    parse_state = MODE_NORMAL;
                end
            end
            default: begin
                parse_state = MODE_NORMAL;
                plain       = 1'b1;
            end
        endcase

        if (plain) begin
            if (ch == CH_BACKSLASH) begin
                parse_state = MODE_ESCAPE;
            end else begin
                vals[n] = ch;
                n++;
            end
        end

        if (last) begin
            parse_state = MODE_NORMAL;
            digits_held = '0;
            hex_value   = '0;
        end

        for (int k = 0; k < n; k++) begin
            awaited_chars.push_back(t_result'{vals[k], k == n - 1, (k == n - 1) && last});
        end
    endtask

    task automatic check_char(input t_result got);
        t_result want;
        if (awaited_chars.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got char %h run_end %b string_end %b",
                     $time, got.out_char, got.run_end, got.string_end);
            mismatch_total++;
        end else begin
            want = awaited_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                $display("%0t: out_char expected %h, got %h", $time, want.out_char, got.out_char);
                mismatch_total++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %b, got %b", $time, want.run_end, got.run_end);
                mismatch_total++;
            end
            if (got.string_end !== want.string_end) begin
                $display("%0t: string_end expected %b, got %b",
                         $time, want.string_end, got.string_end);
                mismatch_total++;
            end
        end
    endtask

    // Output beats are checked before the input beat of the same edge is predicted;
    // a result never leaves in the cycle its input is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = MODE_NORMAL;
            digits_held = '0;
            hex_value   = '0;
            awaited_chars.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_char(t_result'{i_out_mon.out_char, i_out_mon.run_end,
                                     i_out_mon.string_end});
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                unescape_step(i_in_mon.in_char, i_in_mon.in_last);
            end
        end
        o_pending <= awaited_chars.size();
    end

endmodule

### tb/sv/escape_sequence_unescaper_test.sv
`timescale 1ns / 1ps
// Top of the unescaper testbench: clock, reset, character stimulus, output stalls and verdict.
module escape_sequence_unescaper_test;
    import esu_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int N_OPENING    = 29;

    // {in_last, in_char}: mapped escapes, a pass-through escape, a full u escape, a u escape
    // closed by a wide character, an empty u escape, hex at the end of a string and a
    // trailing lone backslash.
    localparam logic [CHAR_W:0] OPENING [N_OPENING] = '{
        {1'b0, 21'h000000}, {1'b0, 21'h1FFFFF},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_T},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_R},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_N},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_A},
        {1'b0, CH_BACKSLASH}, {1'b0, 21'h000071},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_U},
        {1'b0, 21'h000030}, {1'b0, 21'h000039}, {1'b0, 21'h000046}, {1'b0, 21'h000061},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, 21'h000031}, {1'b0, 21'h000131},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, 21'h000067},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b1, 21'h000037},
        {1'b1, CH_BACKSLASH}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int   pending_results;
    int   fail_count;
    int   items_sent = 0;
    int   sink_wait  = 0;
    logic no_idle    = 1'b0;
    logic [CHAR_W-1:0] line_buf[$];

    esu_in_if  char_in ();
    esu_out_if char_out ();

    escape_sequence_unescaper dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_stream  (char_in),
        .o_out_stream (char_out)
    );

    unescape_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (char_in),
        .i_out_mon    (char_out),
        .o_pending    (pending_results),
        .o_fail_count (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // After each output beat the receiver may hold ready low for a random wait, unless no_idle is set.
    always @(posedge i_clk) begin : sink_side
        int w;
        if (!i_rst_n) begin
            char_out.ready <= 1'b0;
            sink_wait      <= 0;
        end else if (char_out.valid && char_out.ready) begin
            w = no_idle ? 0 : $urandom_range(0, 16);
            char_out.ready <= (w == 0);
            sink_wait      <= (w == 0) ? 0 : w - 1;
        end else if (sink_wait > 0) begin
            char_out.ready <= 1'b0;
            sink_wait      <= sink_wait - 1;
        end else begin
            char_out.ready <= 1'b1;
        end
    end

    function automatic logic [CHAR_W-1:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return CHAR_W'("0" + r);
        end else if (r < 16) begin
            return CHAR_W'("A" + r - 10);
        end
        return CHAR_W'("a" + r - 16);
    endfunction

    function automatic logic [CHAR_W-1:0] escape_letter();
        case ($urandom_range(0, 5))
            0:       return CH_T;
            1:       return CH_R;
            2:       return CH_N;
            3:       return CH_A;
            4:       return CH_BACKSLASH;
            default: return CHAR_W'($urandom_range(32, 126));
        endcase
    endfunction

    // Characters far from the grammar: any 21-bit value, wide code points, and wide
    // values whose low seven bits look like a hex digit.
    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 2))
            0:       return CHAR_W'($urandom());
            1:       return CHAR_W'($urandom_range(128, 21'h10FFFF));
            default: return hex_char() | (CHAR_W'($urandom_range(1, 16'h3FFF)) << 7);
        endcase
    endfunction

    task automatic compose_string();
        int tokens;
        line_buf.delete();
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 3))
                        line_buf.push_back(CHAR_W'($urandom_range(32, 126)));
                end
                3, 4: begin
                    line_buf.push_back(CH_BACKSLASH);
                    line_buf.push_back(escape_letter());
                end
                5, 6, 7: begin
                    line_buf.push_back(CH_BACKSLASH);
                    line_buf.push_back(CH_U);
                    repeat ($urandom_range(0, 4)) line_buf.push_back(hex_char());
                end
                8: line_buf.push_back(CH_BACKSLASH);
                default: line_buf.push_back(noise_char());
            endcase
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            char_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_in.valid   <= 1'b1;
        char_in.in_char <= c;
        char_in.in_last <= last;
        do @(posedge i_clk); while (!char_in.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        char_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic paused_once;
        paused_once     = 1'b0;
        char_in.valid   = 1'b0;
        char_in.in_char = '0;
        char_in.in_last = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[i]) send_char(OPENING[i][CHAR_W-1:0], OPENING[i][CHAR_W]);
        wait_drained();

        while (items_sent < N_OPENING + RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            compose_string();
            foreach (line_buf[k]) send_char(line_buf[k], k == line_buf.size() - 1);
            if (!paused_once && items_sent >= N_OPENING + RANDOM_ITEMS / 2) begin
                wait_drained();
                paused_once = 1'b1;
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
